// ----- rtl/core/mrd_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// mrd_pkg
// types and constants shared by the region decoder cells and top level
// ---------------------------------------------------------------------------
package mrd_pkg;

    localparam int MRD_MAX_REGIONS = 16;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_READONLY = 3'd1,
        ST_UNMAPPED = 3'd2,
        ST_FULL     = 3'd3,
        ST_ADDED    = 3'd4
    } t_status;

    typedef enum logic {
        CMD_ADD    = 1'b0,
        CMD_ACCESS = 1'b1
    } t_cmd;

    localparam logic [1:0] SIZE_INVALID = 2'd3;

    typedef struct packed {
        logic        vld;
        logic [31:0] start;
        logic [32:0] end_addr;
        logic [7:0]  tag;
        logic        ro;
    } t_entry;

    typedef struct packed {
        logic        vld;
        t_cmd        cmd;
        logic        skip;
        logic        shifting;
        t_entry      ent;
        logic [31:0] addr;
        logic        write;
        logic [1:0]  size;
        logic        found;
        t_status     status;
        logic [7:0]  hit_tag;
        logic [31:0] offset;
    } t_req;

endpackage
`default_nettype wire

// ----- rtl/core/memory_region_decoder.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// memory_region_decoder
// sorted address region table with lookup of tag, offset and faults
// ---------------------------------------------------------------------------
// Each request travels down a row of MAX_REGIONS cells, one cell per cycle,
// and from the last cell into the output register; one request is in flight
// at a time, and the next request can be taken once the result has been
// captured in the output register.
// A finished result waits in the output register while the next request is
// accepted; while that register is stalled the row holds still and no new
// request is taken.
module memory_region_decoder
    import mrd_pkg::*;
#(
    parameter int MAX_REGIONS = MRD_MAX_REGIONS
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // region_start, region_size, region_tag, region_readonly, address,
    // access_size, access_write, zero fill
    input  wire logic [111:0] s_axis_tdata,
    // command
    input  wire logic [0:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status, hit_tag, region_offset, size_echo, zero fill
    output logic [47:0]       m_axis_tdata
);

    t_req   chain [MAX_REGIONS+1];
    logic   cell_vld [MAX_REGIONS];
    t_req   in_req;
    t_req   r_out;
    logic   r_out_vld;
    logic   r_busy;
    logic   stall;
    logic   accept;
    logic   tail_take;
    logic [31:0] rstart, rsize;
    logic [32:0] sum;

    assign stall         = r_out_vld && !m_axis_tready;
    assign s_axis_tready = !r_busy && !stall;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign tail_take     = chain[MAX_REGIONS].vld && !stall;

    assign rstart = s_axis_tdata[31:0];
    assign rsize  = s_axis_tdata[63:32];
    assign sum    = {1'b0, rstart} + {1'b0, rsize};

    always_comb begin
        in_req              = '0;
        in_req.vld          = accept;
        in_req.cmd          = t_cmd'(s_axis_tuser[0]);
        in_req.ent.vld      = 1'b1;
        in_req.ent.start    = rstart;
        in_req.ent.end_addr = sum[32] ? 33'h1_0000_0000 : sum;
        in_req.ent.tag      = s_axis_tdata[71:64];
        in_req.ent.ro       = s_axis_tdata[72];
        in_req.addr         = s_axis_tdata[104:73];
        in_req.size         = s_axis_tdata[106:105];
        in_req.write        = s_axis_tdata[107];
        if (in_req.cmd == CMD_ADD) begin
            in_req.size = 2'd0;
            if (rsize == 32'd0) begin
                in_req.skip   = 1'b1;
                in_req.status = ST_ADDED;
            end else if (cell_vld[MAX_REGIONS-1]) begin
                in_req.skip   = 1'b1;
                in_req.status = ST_FULL;
            end else begin
                in_req.status = ST_ADDED;
            end
        end else begin
            in_req.status = ST_UNMAPPED;
            in_req.skip   = (in_req.size == SIZE_INVALID);
        end
    end

    assign chain[0] = in_req;

    for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
        mrd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (!stall),
            .i_req   (chain[g]),
            .o_req   (chain[g+1]),
            .o_valid (cell_vld[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (tail_take) begin
                r_busy <= 1'b0;
            end
            if (tail_take) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail_take) begin
            r_out <= chain[MAX_REGIONS];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'd0, r_out.size, r_out.offset, r_out.hit_tag, r_out.status};

endmodule
`default_nettype wire

// ----- rtl/core/mrd_cell.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// mrd_cell
// one table slot: swap-insert for adds, range check for accesses
// ---------------------------------------------------------------------------
module mrd_cell
    import mrd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  t_req      i_req,
    output t_req      o_req,
    output logic      o_valid
);

    t_entry r_entry, n_entry;
    t_req   r_req, n_req;
    logic   r_valid, n_valid;
    logic   hit;

    always_comb begin
        hit = r_valid && (i_req.addr >= r_entry.start) &&
              ({1'b0, i_req.addr} < r_entry.end_addr);
    end

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        n_req   = r_req;
        if (i_en) begin
            n_req = i_req;
            if (i_req.vld && !i_req.skip) begin
                if (i_req.cmd == CMD_ADD) begin
                    if (i_req.ent.vld && (!r_valid || i_req.shifting ||
                                          i_req.ent.start <= r_entry.start)) begin
                        n_entry          = i_req.ent;
                        n_valid          = 1'b1;
                        n_req.ent        = r_entry;
                        n_req.ent.vld    = r_valid;
                        n_req.shifting   = 1'b1;
                    end
                end else if (!i_req.found && hit) begin
                    n_req.found   = 1'b1;
                    n_req.hit_tag = r_entry.tag;
                    n_req.offset  = i_req.addr - r_entry.start;
                    n_req.status  = (r_entry.ro && i_req.write) ? ST_READONLY : ST_OK;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_req   <= '0;
        end else begin
            r_valid <= n_valid;
            r_req   <= n_req;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_req   = r_req;
    assign o_valid = r_valid;

endmodule
`default_nettype wire

// ----- dv/memory_region_decoder_tb.sv -----
// ---------------------------------------------------------------------------
// memory_region_decoder_tb
// self-checking bench for the sorted region table and access decoder
// ---------------------------------------------------------------------------
// A clocked driver takes requests from a queue that an initial block fills,
// starting with a directed set and followed by random adds and accesses.
// Most accesses aim at regions added earlier and at their edges. Each request
// is decoded against a local copy of the region table when it is taken. A
// clocked monitor compares every result with the oldest prediction. Both
// sides idle at random, and the receiver holds off twice for a long stretch.
module memory_region_decoder_tb;
    import mrd_pkg::*;

    localparam int N_RANDOM     = 750;
    localparam int DRAIN_CYCLES = 2 * (MRD_MAX_REGIONS + 1) + 8;

    typedef struct {
        t_cmd        cmd;
        logic [31:0] region_start;
        logic [31:0] region_size;
        logic [7:0]  region_tag;
        logic        region_readonly;
        logic [31:0] address;
        logic [1:0]  access_size;
        logic        access_write;
    } mrd_req_t;

    typedef struct {
        logic [2:0]  status;
        logic [7:0]  hit_tag;
        logic [31:0] region_offset;
        logic [1:0]  size_echo;
    } mrd_decode_t;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // region_start, region_size, region_tag, region_readonly, address,
    // access_size, access_write, zero fill
    logic [111:0] s_axis_tdata  = '0;
    // command
    logic [0:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // status, hit_tag, region_offset, size_echo, zero fill
    logic [47:0]  m_axis_tdata;

    memory_region_decoder #(
        .MAX_REGIONS(MRD_MAX_REGIONS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("[memory_region_decoder] ERROR");
        $finish;
    end

    // local copy of the region table
    logic [31:0] tbl_start [MRD_MAX_REGIONS];
    logic [32:0] tbl_end   [MRD_MAX_REGIONS];
    logic [7:0]  tbl_tag   [MRD_MAX_REGIONS];
    logic        tbl_ro    [MRD_MAX_REGIONS];
    int          tbl_used = 0;

    mrd_req_t    pending_reqs[$];
    mrd_decode_t predicted_decodes[$];
    logic [31:0] known_base[$];
    logic [31:0] known_len[$];
    int          errors = 0;

    logic [31:0] cyc      = '0;
    logic        hold_off = 1'b0;
    logic        calm     = 1'b0;

    function automatic mrd_decode_t decode_request(input mrd_req_t rq);
        mrd_decode_t rs;
        logic [32:0] end_addr;
        int          pos;
        bit          found;
        rs.status        = ST_ADDED;
        rs.hit_tag       = '0;
        rs.region_offset = '0;
        rs.size_echo     = '0;
        if (rq.cmd == CMD_ADD) begin
            // an empty region is never stored, even into a full table
            if (rq.region_size != 0) begin
                if (tbl_used >= MRD_MAX_REGIONS) begin
                    rs.status = ST_FULL;
                end else begin
                    end_addr = {1'b0, rq.region_start} + {1'b0, rq.region_size};
                    if (end_addr > 33'h1_0000_0000)
                        end_addr = 33'h1_0000_0000;
                    pos = 0;
                    while (pos < tbl_used && tbl_start[pos] < rq.region_start)
                        pos++;
                    for (int k = tbl_used; k > pos; k--) begin
                        tbl_start[k] = tbl_start[k - 1];
                        tbl_end[k]   = tbl_end[k - 1];
                        tbl_tag[k]   = tbl_tag[k - 1];
                        tbl_ro[k]    = tbl_ro[k - 1];
                    end
                    tbl_start[pos] = rq.region_start;
                    tbl_end[pos]   = end_addr;
                    tbl_tag[pos]   = rq.region_tag;
                    tbl_ro[pos]    = rq.region_readonly;
                    tbl_used++;
                end
            end
        end else begin
            rs.size_echo = rq.access_size;
            rs.status    = ST_UNMAPPED;
            if (rq.access_size != SIZE_INVALID) begin
                found = 1'b0;
                for (int k = 0; k < tbl_used && !found; k++) begin
                    if (rq.address >= tbl_start[k] && {1'b0, rq.address} < tbl_end[k]) begin
                        rs.hit_tag       = tbl_tag[k];
                        rs.region_offset = rq.address - tbl_start[k];
                        rs.status        = (tbl_ro[k] && rq.access_write) ? ST_READONLY
                                                                          : ST_OK;
                        found            = 1'b1;
                    end
                end
            end
        end
        return rs;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_add(input logic [31:0] start, input logic [31:0] len,
                            input logic [7:0] tag, input logic ro);
        mrd_req_t rq;
        rq.cmd             = CMD_ADD;
        rq.region_start    = start;
        rq.region_size     = len;
        rq.region_tag      = tag;
        rq.region_readonly = ro;
        rq.address         = $urandom;
        rq.access_size     = 2'($urandom_range(0, 3));
        rq.access_write    = 1'($urandom_range(0, 1));
        pending_reqs.push_back(rq);
        if (len != 0) begin
            known_base.push_back(start);
            known_len.push_back(len);
        end
    endtask

    task automatic push_access(input logic [31:0] addr, input logic [1:0] asz,
                               input logic wr);
        mrd_req_t rq;
        rq.cmd             = CMD_ACCESS;
        rq.region_start    = $urandom;
        rq.region_size     = $urandom;
        rq.region_tag      = 8'($urandom_range(0, 255));
        rq.region_readonly = 1'($urandom_range(0, 1));
        rq.address         = addr;
        rq.access_size     = asz;
        rq.access_write    = wr;
        pending_reqs.push_back(rq);
    endtask

    // cycle count, long receiver hold-off and quiet stretches
    always @(posedge i_clk) begin
        cyc      <= cyc + 1;
        hold_off <= (cyc >= 1500 && cyc < 1800) || (cyc >= 12000 && cyc < 12250);
        calm     <= (cyc[9:8] == 2'b11);
    end

    mrd_req_t cur_req;
    int       gap = 0;

    always @(posedge i_clk) begin : driver_p
        int   g;
        logic fire;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap           <= 0;
        end else begin
            fire = s_axis_tvalid && s_axis_tready;
            if (fire)
                predicted_decodes.push_back(decode_request(cur_req));
            if (fire || !s_axis_tvalid) begin
                g = fire ? idle_len() : gap;
                if (g == 0 && pending_reqs.size() != 0) begin
                    cur_req       = pending_reqs.pop_front();
                    s_axis_tdata  <= {4'b0, cur_req.access_write, cur_req.access_size,
                                      cur_req.address, cur_req.region_readonly,
                                      cur_req.region_tag, cur_req.region_size,
                                      cur_req.region_start};
                    s_axis_tuser  <= cur_req.cmd;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                    gap           <= (g > 0) ? g - 1 : 0;
                end
            end
        end
    end

    int stall = 0;

    always @(posedge i_clk) begin : monitor_p
        mrd_decode_t exp_rs;
        int          nxt;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall         <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (predicted_decodes.size() == 0) begin
                    $error("result with nothing outstanding: %h", m_axis_tdata);
                    errors++;
                end else begin
                    exp_rs = predicted_decodes.pop_front();
                    if (m_axis_tdata[2:0] !== exp_rs.status) begin
                        $error("status: expected %0d, got %0d",
                               exp_rs.status, m_axis_tdata[2:0]);
                        errors++;
                    end
                    if (m_axis_tdata[10:3] !== exp_rs.hit_tag) begin
                        $error("hit_tag: expected %h, got %h",
                               exp_rs.hit_tag, m_axis_tdata[10:3]);
                        errors++;
                    end
                    if (m_axis_tdata[42:11] !== exp_rs.region_offset) begin
                        $error("region_offset: expected %h, got %h",
                               exp_rs.region_offset, m_axis_tdata[42:11]);
                        errors++;
                    end
                    if (m_axis_tdata[44:43] !== exp_rs.size_echo) begin
                        $error("size_echo: expected %0d, got %0d",
                               exp_rs.size_echo, m_axis_tdata[44:43]);
                        errors++;
                    end
                end
            end
            nxt           = (stall > 0) ? stall - 1 : idle_len();
            stall         <= nxt;
            m_axis_tready <= (nxt == 0) && !hold_off;
        end
    end

    initial begin : stimulus_p
        int          r;
        int          k;
        logic [31:0] start;
        logic [31:0] len;
        logic [31:0] addr;
        logic [1:0]  asz;

        // empty table, including the meaningless size code
        push_access(32'h0000_0000, 2'd0, 1'b0);
        push_access(32'hFFFF_FFFF, SIZE_INVALID, 1'b1);
        // empty region stores nothing
        push_add(32'h0000_1000, 32'h0, 8'h77, 1'b0);
        push_access(32'h0000_1000, 2'd2, 1'b0);
        push_add(32'h0000_0000, 32'h0000_1000, 8'h00, 1'b0);
        // end saturates at the top of the address space
        push_add(32'hFFFF_F000, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        push_access(32'hFFFF_FFFF, 2'd2, 1'b1);
        push_access(32'hFFFF_F000, 2'd1, 1'b0);
        push_access(32'h0000_0FFF, 2'd0, 1'b1);
        push_access(32'h0000_1000, 2'd0, 1'b0);
        // equal start, newest wins
        push_add(32'h0000_0000, 32'h0000_0010, 8'h5A, 1'b1);
        push_access(32'h0000_0008, 2'd1, 1'b1);
        push_access(32'h0000_0010, 2'd2, 1'b1);
        push_access(32'h0000_0004, SIZE_INVALID, 1'b0);
        // end exactly at the top, no saturation
        push_add(32'h8000_0000, 32'h8000_0000, 8'hA5, 1'b0);
        push_access(32'hFFFF_FFFF, 2'd0, 1'b1);
        push_add(32'h8000_0000, 32'h0000_0001, 8'h3C, 1'b1);
        push_access(32'h8000_0000, 2'd2, 1'b1);
        push_access(32'h8000_0001, 2'd2, 1'b1);

        // random part, the table fills early and then stays full
        for (int i = 0; i < N_RANDOM; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                case ($urandom_range(0, 3))
                    0: start = $urandom;
                    1: start = known_base[$urandom_range(0, known_base.size() - 1)];
                    2: start = $urandom & 32'hFFFF_F000;
                    default: start = 32'hFFFF_FFFF - $urandom_range(0, 255);
                endcase
                r = $urandom_range(0, 99);
                if (r < 10)
                    len = 32'h0;
                else if (r < 25)
                    len = $urandom;
                else
                    len = $urandom_range(1, 32'h2000);
                push_add(start, len, 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            end else begin
                if (r < 78) begin
                    k = $urandom_range(0, known_base.size() - 1);
                    case ($urandom_range(0, 3))
                        0: addr = known_base[k];
                        1: addr = known_base[k] + known_len[k] - 1;
                        2: addr = known_base[k] + known_len[k];
                        default: addr = known_base[k] + ($urandom % known_len[k]);
                    endcase
                end else begin
                    addr = $urandom;
                end
                asz = ($urandom_range(0, 19) == 0) ? SIZE_INVALID
                                                   : 2'($urandom_range(0, 2));
                push_access(addr, asz, 1'($urandom_range(0, 1)));
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || s_axis_tvalid || predicted_decodes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("[memory_region_decoder] OK");
        else
            $display("[memory_region_decoder] ERROR");
        $finish;
    end

endmodule
